>>> rtl/core/sbl_pkg.sv
package sbl_pkg;

   // operation codes carried in the func field
   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_DELETE = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_DONE      = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   // request transaction
   typedef struct packed {
      logic              func;
      logic signed [7:0] value;
   } req_type;

   // response transaction
   typedef struct packed {
      logic [1:0] status;
      logic [4:0] entry_count;
      logic       is_empty;
   } rsp_type;

   // control broadcast from the sequencer to every cell
   typedef struct packed {
      logic              latch;
      logic              do_insert;
      logic              do_delete;
      logic signed [7:0] value;
   } cell_ctl_type;

endpackage

>>> rtl/core/sorted_byte_list_insert_delete_unit.sv
// Sorted list of signed bytes, ascending, up to CAPACITY entries.
// Request channel (req_valid/req_ready/req_payload): func selects insert
// (placed in front of the first entry not below the value) or delete (first
// equal entry removed). Response channel (rsp_valid/rsp_ready/rsp_payload):
// one response per request with status, entry count and empty flag.
// Each slot is a cell holding one entry; all cells compare in parallel and
// shift one place toward their neighbor, so the list size does not change
// the timing.
// The edge that takes a request captures the per-cell compare flags; a
// later edge, once the output register is free, merges the match flags,
// shifts the cells and loads the response. No new request is taken until
// the current one has committed.
// A new request may be taken while the previous response is still held;
// if the receiver stalls, that request waits in the evaluate state until the
// output register frees up, and no further request is taken.
// Reset empties the list and drops any pending response; entry contents
// are not cleared, only the per-cell valid bits.
module sorted_byte_list_insert_delete_unit #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbl_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbl_pkg::rsp_type rsp_payload
);

   localparam int CountWidth = $clog2(CAPACITY + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EVAL = 1'b1;

   logic                  state_ff;
   logic                  state_in;
   logic                  func_ff;
   logic                  func_in;
   logic signed [7:0]     value_ff;
   logic signed [7:0]     value_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   sbl_pkg::rsp_type      rsp_payload_ff;
   sbl_pkg::rsp_type      rsp_payload_in;

   logic                  req_take;
   logic                  commit;
   logic                  full;
   logic                  found;
   sbl_pkg::cell_ctl_type ctl;

   logic signed [7:0]     cell_entry [CAPACITY];
   logic [CAPACITY-1:0]   cell_valid;
   logic [CAPACITY-1:0]   cell_ins;
   logic [CAPACITY-1:0]   cell_ge;
   logic [CAPACITY-1:0]   cell_hit;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   // finish only when the output register is free
   assign commit    = (state_ff == ST_EVAL) && (!rsp_valid_ff || rsp_ready);
   assign full      = cell_valid[CAPACITY-1];
   assign found     = |cell_hit;

   // broadcast to the cells
   always_comb begin
      ctl.latch     = req_take;
      ctl.value     = req_take ? req_payload.value : value_ff;
      ctl.do_insert = commit && (func_ff == sbl_pkg::FUNC_INSERT) && !full;
      ctl.do_delete = commit && (func_ff == sbl_pkg::FUNC_DELETE) && found;
   end

   // row of cells, each wired to both neighbors
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [7:0] left_entry;
      logic              left_valid;
      logic              left_ins;
      logic              left_ge;
      logic signed [7:0] right_entry;
      logic              right_valid;

      if (i == 0) begin : g_head
         assign left_entry = 8'sd0;
         assign left_valid = 1'b1;
         assign left_ins   = 1'b0;
         assign left_ge    = 1'b0;
      end else begin : g_body
         assign left_entry = cell_entry[i-1];
         assign left_valid = cell_valid[i-1];
         assign left_ins   = cell_ins[i-1];
         assign left_ge    = cell_ge[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_entry = 8'sd0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      sbl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .left_entry  (left_entry),
         .left_valid  (left_valid),
         .left_ins    (left_ins),
         .left_ge     (left_ge),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .ins         (cell_ins[i]),
         .ge          (cell_ge[i]),
         .hit         (cell_hit[i])
      );
   end

   // sequencer, operation holding registers and entry count
   always_comb begin
      state_in = state_ff;
      func_in  = func_ff;
      value_in = value_ff;
      count_in = count_ff;
      if (req_take) begin
         state_in = ST_EVAL;
         func_in  = req_payload.func;
         value_in = req_payload.value;
      end else if (commit) begin
         state_in = ST_IDLE;
      end
      if (ctl.do_insert) begin
         count_in = count_ff + CountWidth'(1);
      end else if (ctl.do_delete) begin
         count_in = count_ff - CountWidth'(1);
      end
   end

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         if (func_ff == sbl_pkg::FUNC_INSERT) begin
            rsp_payload_in.status = full ? sbl_pkg::STATUS_FULL : sbl_pkg::STATUS_DONE;
         end else begin
            rsp_payload_in.status = found ? sbl_pkg::STATUS_DONE
                                          : sbl_pkg::STATUS_NOT_FOUND;
         end
         rsp_payload_in.entry_count = 5'(count_in);
         rsp_payload_in.is_empty    = (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      value_ff       <= value_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> rtl/core/sbl_cell.sv
// One slot of the sorted list. Holds one entry and its valid bit, and
// trades entries with its neighbors when the list opens or closes a gap.
module sbl_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  sbl_pkg::cell_ctl_type ctl,
   input  logic signed [7:0]    left_entry,
   input  logic                 left_valid,
   input  logic                 left_ins,
   input  logic                 left_ge,
   input  logic signed [7:0]    right_entry,
   input  logic                 right_valid,
   output logic signed [7:0]    entry,
   output logic                 valid,
   output logic                 ins,
   output logic                 ge,
   output logic                 hit
);

   logic signed [7:0] entry_ff;
   logic signed [7:0] entry_in;
   logic              valid_ff;
   logic              valid_in;
   logic              ge_ff;
   logic              ge_in;
   logic              eq_ff;
   logic              eq_in;

   // compare flags, captured when the transaction is taken
   always_comb begin
      ge_in = ge_ff;
      eq_in = eq_ff;
      if (ctl.latch) begin
         ge_in = valid_ff && (ctl.value <= entry_ff);
         eq_in = valid_ff && (ctl.value == entry_ff);
      end
   end

   // insert point is the first slot that is empty or not below the value
   assign ins = ge_ff | ~valid_ff;
   assign ge  = ge_ff;
   // first matching slot of the list
   assign hit = eq_ff & ~left_ge;

   // shift right on insert, shift left on delete
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (ctl.do_insert && ins) begin
         entry_in = left_ins ? left_entry : ctl.value;
         valid_in = left_valid;
      end else if (ctl.do_delete && ge_ff) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      ge_ff    <= ge_in;
      eq_ff    <= eq_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;

endmodule

>>> rtl/core/sbl_check.sv
// Port-level checks for the sorted list unit.
module sbl_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sbl_pkg::rsp_type rsp_payload
);

   // a stalled response holds its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // an empty list always reports a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_empty |-> rsp_payload.entry_count == 5'd0)
      else $error("empty flag with nonzero count");

   // only defined status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == sbl_pkg::STATUS_DONE ||
                     rsp_payload.status == sbl_pkg::STATUS_FULL ||
                     rsp_payload.status == sbl_pkg::STATUS_NOT_FOUND))
      else $error("undefined status code");

   // a rejected insert means the list still holds entries
   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == sbl_pkg::STATUS_FULL |-> !rsp_payload.is_empty)
      else $error("full status on an empty list");

   // a taken transaction occupies the unit for the following cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while evaluating");

endmodule

bind sorted_byte_list_insert_delete_unit sbl_check u_sbl_check (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

>>> verif/tb.sv
module tb;

   localparam int LIST_CAPACITY  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_CYCLES    = 90;

   logic             clock = 1'b0;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   sbl_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   sbl_pkg::rsp_type rsp_payload;

   // shadow copy of the sorted list and responses still owed by the block
   logic signed [7:0] model_list[$];
   sbl_pkg::rsp_type  pending_rsp_q[$];

   int err_count     = 0;
   int idle_cycles   = 0;
   int rx_hold_count = 0;
   bit tx_idle       = 1'b1;
   bit rx_idle       = 1'b1;

   sorted_byte_list_insert_delete_unit #(
      .CAPACITY(LIST_CAPACITY)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // apply one operation to the shadow list and return the response it owes
   function automatic sbl_pkg::rsp_type sorted_list_apply(input logic f,
                                                          input logic signed [7:0] v);
      sbl_pkg::rsp_type r;
      int               pos;
      r.status = sbl_pkg::STATUS_DONE;
      pos = 0;
      if (f == sbl_pkg::FUNC_INSERT) begin
         if (model_list.size() >= LIST_CAPACITY) begin
            r.status = sbl_pkg::STATUS_FULL;
         end else begin
            while (pos < model_list.size() && v > model_list[pos]) pos++;
            model_list.insert(pos, v);
         end
      end else begin
         while (pos < model_list.size() && model_list[pos] != v) pos++;
         if (pos >= model_list.size()) r.status = sbl_pkg::STATUS_NOT_FOUND;
         else model_list.delete(pos);
      end
      r.entry_count = 5'(model_list.size());
      r.is_empty    = (model_list.size() == 0);
      return r;
   endfunction

   // predict on each accepted request, then check each accepted response
   always @(posedge clock) begin
      sbl_pkg::rsp_type exp_rsp;
      if (!reset) begin
         if (req_valid && req_ready)
            pending_rsp_q.push_back(sorted_list_apply(req_payload.func, req_payload.value));
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp_q.size() == 0) begin
               $error("response transaction with nothing pending: status=%0d count=%0d",
                      rsp_payload.status, rsp_payload.entry_count);
               err_count++;
            end else begin
               exp_rsp = pending_rsp_q.pop_front();
               if (rsp_payload.status !== exp_rsp.status) begin
                  $error("status: expected %0d, actual %0d", exp_rsp.status,
                         rsp_payload.status);
                  err_count++;
               end
               if (rsp_payload.entry_count !== exp_rsp.entry_count) begin
                  $error("entry_count: expected %0d, actual %0d", exp_rsp.entry_count,
                         rsp_payload.entry_count);
                  err_count++;
               end
               if (rsp_payload.is_empty !== exp_rsp.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d", exp_rsp.is_empty,
                         rsp_payload.is_empty);
                  err_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_byte_list_insert_delete_unit verification failed");
            $finish;
         end
      end
   end

   // response side: random stalls, plus a long hold-off on request
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rx_hold_count > 0) begin
            rsp_ready <= 1'b0;
            repeat (rx_hold_count) @(posedge clock);
            rx_hold_count = 0;
         end
         stall = rx_idle ? $urandom_range(11, 0) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // send one request transaction; returns at the edge it is accepted
   task automatic send_req(input logic f, input logic signed [7:0] v);
      sbl_pkg::req_type item;
      int               gap;
      gap = tx_idle ? $urandom_range(11, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.func  = f;
      item.value = v;
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender pauses until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_delete();
      send_req(sbl_pkg::FUNC_DELETE, 8'sd0);
      send_req(sbl_pkg::FUNC_DELETE, -8'sd128);
      wait_drained();
   endtask

   // extreme values, delete of zero, delete of a missing value
   task automatic test_extremes();
      send_req(sbl_pkg::FUNC_INSERT, 8'sd127);
      send_req(sbl_pkg::FUNC_INSERT, -8'sd128);
      send_req(sbl_pkg::FUNC_INSERT, 8'sd0);
      send_req(sbl_pkg::FUNC_INSERT, -8'sd1);
      send_req(sbl_pkg::FUNC_DELETE, 8'sd0);
      send_req(sbl_pkg::FUNC_DELETE, 8'sd5);
      wait_drained();
   endtask

   // fill to capacity with duplicates, then overflow
   task automatic test_fill_and_overflow();
      logic signed [7:0] fill_vals[13];
      fill_vals = '{-8'sd1, -8'sd1, 8'sd64, -8'sd64, 8'sd1, 8'sd2, 8'sd100,
                    -8'sd100, 8'sd50, -8'sd50, 8'sd10, -8'sd10, 8'sd126};
      foreach (fill_vals[i]) send_req(sbl_pkg::FUNC_INSERT, fill_vals[i]);
      send_req(sbl_pkg::FUNC_INSERT, -8'sd1);
      send_req(sbl_pkg::FUNC_INSERT, 8'sd127);
      send_req(sbl_pkg::FUNC_DELETE, 8'sd127);
      send_req(sbl_pkg::FUNC_DELETE, -8'sd128);
      wait_drained();
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      tx_idle = 1'b0;
      rx_hold_count = HOLD_CYCLES;
      repeat (12) send_req(logic'($urandom_range(1, 0)), 8'($urandom));
      wait_drained();
      tx_idle = 1'b1;
   endtask

   // phases with varied insert bias, value spread and idling
   task automatic test_random_mix(input int n_items);
      int                sent;
      int                ins_pct;
      int                len;
      bit                narrow;
      logic [7:0]        base;
      logic              f;
      logic signed [7:0] v;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(3, 0))
            0: ins_pct = 25;
            1: ins_pct = 50;
            2: ins_pct = 70;
            default: ins_pct = 90;
         endcase
         narrow  = $urandom_range(1, 0);
         base    = 8'($urandom);
         tx_idle = ($urandom_range(3, 0) != 0);
         rx_idle = ($urandom_range(3, 0) != 0);
         len     = $urandom_range(60, 20);
         repeat (len) begin
            f = ($urandom_range(99, 0) < ins_pct) ? sbl_pkg::FUNC_INSERT
                                                   : sbl_pkg::FUNC_DELETE;
            if (f == sbl_pkg::FUNC_DELETE && model_list.size() > 0 &&
                $urandom_range(3, 0) != 0)
               v = model_list[$urandom_range(model_list.size() - 1, 0)];
            else if (narrow)
               v = $signed(8'(base + 8'($urandom_range(7, 0))));
            else
               v = $signed(8'($urandom));
            send_req(f, v);
            sent++;
         end
         // sometimes let the list settle between phases
         if ($urandom_range(3, 0) == 0) wait_drained();
      end
      wait_drained();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_delete();
      test_extremes();
      test_fill_and_overflow();
      test_backpressure();
      test_random_mix(500);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $error("%0d response transactions never arrived", pending_rsp_q.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("sorted_byte_list_insert_delete_unit verification clean");
      end else begin
         $display("sorted_byte_list_insert_delete_unit verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sbl_pkg.sv
rtl/core/sbl_cell.sv
rtl/core/sorted_byte_list_insert_delete_unit.sv
rtl/core/sbl_check.sv
verif/tb.sv
